// File: rtl/cpu8ex_pkg.sv
package cpu8ex_pkg;

   // operation codes
   localparam logic [5:0] KIND_ADC    = 6'd0;
   localparam logic [5:0] KIND_SBC    = 6'd1;
   localparam logic [5:0] KIND_AND    = 6'd2;
   localparam logic [5:0] KIND_ORA    = 6'd3;
   localparam logic [5:0] KIND_EOR    = 6'd4;
   localparam logic [5:0] KIND_CMP    = 6'd5;
   localparam logic [5:0] KIND_CPX    = 6'd6;
   localparam logic [5:0] KIND_CPY    = 6'd7;
   localparam logic [5:0] KIND_BIT    = 6'd8;
   localparam logic [5:0] KIND_LDA    = 6'd9;
   localparam logic [5:0] KIND_LDX    = 6'd10;
   localparam logic [5:0] KIND_LDY    = 6'd11;
   localparam logic [5:0] KIND_ASL    = 6'd12;
   localparam logic [5:0] KIND_LSR    = 6'd13;
   localparam logic [5:0] KIND_ROL    = 6'd14;
   localparam logic [5:0] KIND_ROR    = 6'd15;
   localparam logic [5:0] KIND_INC    = 6'd16;
   localparam logic [5:0] KIND_DEC    = 6'd17;
   localparam logic [5:0] KIND_SLO    = 6'd18;
   localparam logic [5:0] KIND_INX    = 6'd19;
   localparam logic [5:0] KIND_DEX    = 6'd20;
   localparam logic [5:0] KIND_INY    = 6'd21;
   localparam logic [5:0] KIND_DEY    = 6'd22;
   localparam logic [5:0] KIND_TAX    = 6'd23;
   localparam logic [5:0] KIND_TAY    = 6'd24;
   localparam logic [5:0] KIND_TXA    = 6'd25;
   localparam logic [5:0] KIND_TYA    = 6'd26;
   localparam logic [5:0] KIND_TSX    = 6'd27;
   localparam logic [5:0] KIND_TXS    = 6'd28;
   localparam logic [5:0] KIND_CLC    = 6'd29;
   localparam logic [5:0] KIND_SEC    = 6'd30;
   localparam logic [5:0] KIND_CLD    = 6'd31;
   localparam logic [5:0] KIND_SED    = 6'd32;
   localparam logic [5:0] KIND_CLI    = 6'd33;
   localparam logic [5:0] KIND_SEI    = 6'd34;
   localparam logic [5:0] KIND_CLV    = 6'd35;
   localparam logic [5:0] KIND_PLP    = 6'd36;
   localparam logic [5:0] KIND_STA    = 6'd37;
   localparam logic [5:0] KIND_STX    = 6'd38;
   localparam logic [5:0] KIND_STY    = 6'd39;
   localparam logic [5:0] KIND_RDP    = 6'd40;
   localparam logic [5:0] KIND_BRANCH = 6'd41;

   // branch test flag select (condition bits 2:1)
   localparam logic [1:0] COND_SEL_N = 2'd0;
   localparam logic [1:0] COND_SEL_V = 2'd1;
   localparam logic [1:0] COND_SEL_C = 2'd2;
   localparam logic [1:0] COND_SEL_Z = 2'd3;

   // status bit positions
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_U = 5;
   localparam int FLAG_B = 4;
   localparam int FLAG_D = 3;
   localparam int FLAG_I = 2;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] STATUS_RESET = 8'h20;

   typedef struct packed {
      logic [5:0]  kind;
      logic [7:0]  operand;
      logic        on_memory;
      logic [2:0]  condition;
      logic [15:0] pc;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic        write_back;
      logic [7:0]  status;
      logic        branch_taken;
      logic [15:0] next_pc;
      logic        page_crossed;
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] status;
   } regs_type;

endpackage

// File: rtl/cpu8_alu_flags_execute_top.sv
// channel   handshake              payload                 direction
// req       req_valid / req_ready  req_data  (req_type)    in
// rsp       rsp_valid / rsp_ready  rsp_data  (rsp_type)    out
//
// one operation per cycle sustained while rsp_ready is high; an accepted item sits
// in the input register and is executed in the following cycle unless the result
// register is stalled, the single alu pass from that register into the result
// register and the register file. the result is offered from the result register.
// reset clears a, x, y and sp to zero and the status to 0x20, no items held.
// a stalled result holds the input register; a new item is still taken
// in the cycle the held one moves into the result register.
module cpu8_alu_flags_execute_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cpu8ex_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cpu8ex_pkg::rsp_type  rsp_data
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   cpu8ex_pkg::req_type  in_item_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   cpu8ex_pkg::rsp_type  rsp_item_ff;
   cpu8ex_pkg::rsp_type  rsp_item_in;
   cpu8ex_pkg::regs_type regs_ff;
   cpu8ex_pkg::regs_type regs_in;
   logic                 advance;

   // execute when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // execute stage
   cpu8ex_alu u_alu (
      .item      (in_item_ff),
      .regs_cur  (regs_ff),
      .rsp_out   (rsp_item_in),
      .regs_next (regs_in)
   );

   // handshake state
   always_comb begin
      in_valid_in  = (in_valid_ff && !advance) || (req_valid && req_ready);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   // control and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         regs_ff      <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: 8'd0,
                           status: cpu8ex_pkg::STATUS_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            regs_ff <= regs_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

`ifndef SYNTHESIS
   // executed item always lands in the result register
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("executed item missing from result register");

   // register file only moves when an item executes
   assert property (@(posedge clock) disable iff (reset) !advance |=> $stable(regs_ff))
      else $error("register file changed without an executed item");

   // waiting item is neither lost nor altered
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting item dropped or changed");

   // unused bit stays set and break bit stays clear
   assert property (@(posedge clock) disable iff (reset)
      regs_ff.status[cpu8ex_pkg::FLAG_U] && !regs_ff.status[cpu8ex_pkg::FLAG_B])
      else $error("status bits 5 and 4 out of line");
`endif

endmodule

// File: rtl/cpu8ex_alu.sv
module cpu8ex_alu (
   input  cpu8ex_pkg::req_type  item,
   input  cpu8ex_pkg::regs_type regs_cur,
   output cpu8ex_pkg::rsp_type  rsp_out,
   output cpu8ex_pkg::regs_type regs_next
);

   // replace N and Z of a status byte from a value
   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[cpu8ex_pkg::FLAG_N] = v[7];
      q[cpu8ex_pkg::FLAG_Z] = (v == 8'd0);
      return q;
   endfunction

   logic [7:0] a;
   logic [7:0] op;
   logic       cin;

   assign a   = regs_cur.acc;
   assign op  = item.operand;
   assign cin = regs_cur.status[cpu8ex_pkg::FLAG_C];

   // binary adder, operand inverted for subtract
   logic [7:0] add_val;
   logic [8:0] bin_sum;
   logic       bin_v;

   assign add_val = (item.kind == cpu8ex_pkg::KIND_SBC) ? ~op : op;
   assign bin_sum = {1'b0, a} + {1'b0, add_val} + {8'd0, cin};
   assign bin_v   = ~(a[7] ^ add_val[7]) & (a[7] ^ bin_sum[7]);

   // decimal add, nmos flag behavior
   logic [4:0] da_lo5;
   logic       da_half;
   logic [3:0] da_lo;
   logic [4:0] da_hi5;
   logic       da_v;
   logic       da_c;
   logic [3:0] da_hi;

   assign da_lo5  = {1'b0, a[3:0]} + {1'b0, op[3:0]} + {4'd0, cin};
   assign da_half = (da_lo5 > 5'd9);
   assign da_lo   = da_half ? (da_lo5[3:0] + 4'd6) : da_lo5[3:0];
   assign da_hi5  = {1'b0, a[7:4]} + {1'b0, op[7:4]} + {4'd0, da_half};
   assign da_v    = (da_hi5[3] ^ a[7]) & ~(a[7] ^ op[7]);
   assign da_c    = (da_hi5 > 5'd9);
   assign da_hi   = da_c ? (da_hi5[3:0] + 4'd6) : da_hi5[3:0];

   // decimal subtract, nmos flag behavior
   logic       ds_br;
   logic [4:0] ds_lo5;
   logic [3:0] ds_lo;
   logic [4:0] ds_hi5;
   logic [3:0] ds_hi;
   logic       ds_v;

   assign ds_br  = ~cin;
   assign ds_lo5 = {1'b0, a[3:0]} - {1'b0, op[3:0]} - {4'd0, ds_br};
   assign ds_lo  = ds_lo5[4] ? (ds_lo5[3:0] - 4'd6) : ds_lo5[3:0];
   assign ds_hi5 = {1'b0, a[7:4]} - {1'b0, op[7:4]} - {4'd0, ds_lo5[4]};
   assign ds_hi  = ds_hi5[4] ? (ds_hi5[3:0] - 4'd6) : ds_hi5[3:0];
   assign ds_v   = (op[7] ^ a[7]) & ~(bin_sum[7] ^ op[7]);

   // compare against a, x or y
   logic [7:0] cmp_src;
   logic [7:0] cmp_diff;

   always_comb begin
      case (item.kind)
         cpu8ex_pkg::KIND_CPX: cmp_src = regs_cur.x;
         cpu8ex_pkg::KIND_CPY: cmp_src = regs_cur.y;
         default:              cmp_src = a;
      endcase
   end

   assign cmp_diff = cmp_src - op;

   // shifts and rotates
   logic [7:0] sh_src;
   logic [7:0] sh_res;
   logic       sh_carry;

   assign sh_src = item.on_memory ? op : a;

   always_comb begin
      case (item.kind)
         cpu8ex_pkg::KIND_ASL: begin
            sh_res   = {sh_src[6:0], 1'b0};
            sh_carry = sh_src[7];
         end
         cpu8ex_pkg::KIND_LSR: begin
            sh_res   = {1'b0, sh_src[7:1]};
            sh_carry = sh_src[0];
         end
         cpu8ex_pkg::KIND_ROL: begin
            sh_res   = {sh_src[6:0], cin};
            sh_carry = sh_src[7];
         end
         default: begin
            sh_res   = {cin, sh_src[7:1]};
            sh_carry = sh_src[0];
         end
      endcase
   end

   // branch test and target
   logic        br_flag;
   logic        br_taken;
   logic [15:0] br_target;

   always_comb begin
      case (item.condition[2:1])
         cpu8ex_pkg::COND_SEL_N: br_flag = regs_cur.status[cpu8ex_pkg::FLAG_N];
         cpu8ex_pkg::COND_SEL_V: br_flag = regs_cur.status[cpu8ex_pkg::FLAG_V];
         cpu8ex_pkg::COND_SEL_C: br_flag = regs_cur.status[cpu8ex_pkg::FLAG_C];
         default:                br_flag = regs_cur.status[cpu8ex_pkg::FLAG_Z];
      endcase
   end

   assign br_taken  = item.condition[0] ? br_flag : ~br_flag;
   assign br_target = item.pc + {{8{op[7]}}, op};

   // misc byte results
   logic [7:0] slo_mem;
   logic [7:0] inc_mem;
   logic [7:0] dec_mem;

   assign slo_mem = {op[6:0], 1'b0};
   assign inc_mem = op + 8'd1;
   assign dec_mem = op - 8'd1;

   // operation select
   cpu8ex_pkg::regs_type nxt;
   logic [7:0]           res_byte;
   logic                 wb;
   logic                 taken;
   logic [15:0]          npc;
   logic                 crossed;

   always_comb begin
      nxt      = regs_cur;
      res_byte = 8'd0;
      wb       = 1'b0;
      taken    = 1'b0;
      npc      = item.pc;
      crossed  = 1'b0;
      case (item.kind) inside
         cpu8ex_pkg::KIND_ADC: begin
            if (regs_cur.status[cpu8ex_pkg::FLAG_D]) begin
               nxt.status[cpu8ex_pkg::FLAG_Z] = (bin_sum[7:0] == 8'd0);
               nxt.status[cpu8ex_pkg::FLAG_N] = da_hi5[3];
               nxt.status[cpu8ex_pkg::FLAG_V] = da_v;
               nxt.status[cpu8ex_pkg::FLAG_C] = da_c;
               nxt.acc = {da_hi, da_lo};
            end else begin
               nxt.status = with_nz(regs_cur.status, bin_sum[7:0]);
               nxt.status[cpu8ex_pkg::FLAG_V] = bin_v;
               nxt.status[cpu8ex_pkg::FLAG_C] = bin_sum[8];
               nxt.acc = bin_sum[7:0];
            end
         end
         cpu8ex_pkg::KIND_SBC: begin
            if (regs_cur.status[cpu8ex_pkg::FLAG_D]) begin
               nxt.status[cpu8ex_pkg::FLAG_Z] = (bin_sum[7:0] == 8'd0);
               nxt.status[cpu8ex_pkg::FLAG_N] = ds_hi5[3];
               nxt.status[cpu8ex_pkg::FLAG_V] = ds_v;
               nxt.status[cpu8ex_pkg::FLAG_C] = ~ds_hi5[4];
               nxt.acc = {ds_hi, ds_lo};
            end else begin
               nxt.status = with_nz(regs_cur.status, bin_sum[7:0]);
               nxt.status[cpu8ex_pkg::FLAG_V] = bin_v;
               nxt.status[cpu8ex_pkg::FLAG_C] = bin_sum[8];
               nxt.acc = bin_sum[7:0];
            end
         end
         cpu8ex_pkg::KIND_AND: begin
            nxt.acc    = a & op;
            nxt.status = with_nz(regs_cur.status, a & op);
         end
         cpu8ex_pkg::KIND_ORA: begin
            nxt.acc    = a | op;
            nxt.status = with_nz(regs_cur.status, a | op);
         end
         cpu8ex_pkg::KIND_EOR: begin
            nxt.acc    = a ^ op;
            nxt.status = with_nz(regs_cur.status, a ^ op);
         end
         [cpu8ex_pkg::KIND_CMP:cpu8ex_pkg::KIND_CPY]: begin
            nxt.status = with_nz(regs_cur.status, cmp_diff);
            nxt.status[cpu8ex_pkg::FLAG_C] = (op <= cmp_src);
         end
         cpu8ex_pkg::KIND_BIT: begin
            nxt.status[cpu8ex_pkg::FLAG_N] = op[7];
            nxt.status[cpu8ex_pkg::FLAG_V] = op[6];
            nxt.status[cpu8ex_pkg::FLAG_Z] = ((a & op) == 8'd0);
         end
         cpu8ex_pkg::KIND_LDA: begin
            nxt.acc    = op;
            nxt.status = with_nz(regs_cur.status, op);
         end
         cpu8ex_pkg::KIND_LDX: begin
            nxt.x      = op;
            nxt.status = with_nz(regs_cur.status, op);
         end
         cpu8ex_pkg::KIND_LDY: begin
            nxt.y      = op;
            nxt.status = with_nz(regs_cur.status, op);
         end
         [cpu8ex_pkg::KIND_ASL:cpu8ex_pkg::KIND_ROR]: begin
            nxt.status = with_nz(regs_cur.status, sh_res);
            nxt.status[cpu8ex_pkg::FLAG_C] = sh_carry;
            if (item.on_memory) begin
               res_byte = sh_res;
               wb       = 1'b1;
            end else begin
               nxt.acc = sh_res;
            end
         end
         cpu8ex_pkg::KIND_INC: begin
            res_byte   = inc_mem;
            wb         = 1'b1;
            nxt.status = with_nz(regs_cur.status, inc_mem);
         end
         cpu8ex_pkg::KIND_DEC: begin
            res_byte   = dec_mem;
            wb         = 1'b1;
            nxt.status = with_nz(regs_cur.status, dec_mem);
         end
         cpu8ex_pkg::KIND_SLO: begin
            res_byte   = slo_mem;
            wb         = 1'b1;
            nxt.acc    = a | slo_mem;
            nxt.status = with_nz(regs_cur.status, a | slo_mem);
            nxt.status[cpu8ex_pkg::FLAG_C] = op[7];
         end
         cpu8ex_pkg::KIND_INX: begin
            nxt.x      = regs_cur.x + 8'd1;
            nxt.status = with_nz(regs_cur.status, regs_cur.x + 8'd1);
         end
         cpu8ex_pkg::KIND_DEX: begin
            nxt.x      = regs_cur.x - 8'd1;
            nxt.status = with_nz(regs_cur.status, regs_cur.x - 8'd1);
         end
         cpu8ex_pkg::KIND_INY: begin
            nxt.y      = regs_cur.y + 8'd1;
            nxt.status = with_nz(regs_cur.status, regs_cur.y + 8'd1);
         end
         cpu8ex_pkg::KIND_DEY: begin
            nxt.y      = regs_cur.y - 8'd1;
            nxt.status = with_nz(regs_cur.status, regs_cur.y - 8'd1);
         end
         cpu8ex_pkg::KIND_TAX: begin
            nxt.x      = a;
            nxt.status = with_nz(regs_cur.status, a);
         end
         cpu8ex_pkg::KIND_TAY: begin
            nxt.y      = a;
            nxt.status = with_nz(regs_cur.status, a);
         end
         cpu8ex_pkg::KIND_TXA: begin
            nxt.acc    = regs_cur.x;
            nxt.status = with_nz(regs_cur.status, regs_cur.x);
         end
         cpu8ex_pkg::KIND_TYA: begin
            nxt.acc    = regs_cur.y;
            nxt.status = with_nz(regs_cur.status, regs_cur.y);
         end
         cpu8ex_pkg::KIND_TSX: begin
            nxt.x      = regs_cur.sp;
            nxt.status = with_nz(regs_cur.status, regs_cur.sp);
         end
         cpu8ex_pkg::KIND_TXS: nxt.sp = regs_cur.x;
         cpu8ex_pkg::KIND_CLC: nxt.status[cpu8ex_pkg::FLAG_C] = 1'b0;
         cpu8ex_pkg::KIND_SEC: nxt.status[cpu8ex_pkg::FLAG_C] = 1'b1;
         cpu8ex_pkg::KIND_CLD: nxt.status[cpu8ex_pkg::FLAG_D] = 1'b0;
         cpu8ex_pkg::KIND_SED: nxt.status[cpu8ex_pkg::FLAG_D] = 1'b1;
         cpu8ex_pkg::KIND_CLI: nxt.status[cpu8ex_pkg::FLAG_I] = 1'b0;
         cpu8ex_pkg::KIND_SEI: nxt.status[cpu8ex_pkg::FLAG_I] = 1'b1;
         cpu8ex_pkg::KIND_CLV: nxt.status[cpu8ex_pkg::FLAG_V] = 1'b0;
         cpu8ex_pkg::KIND_PLP: begin
            // popped status: unused bit forced high, break bit forced low
            nxt.status = op;
            nxt.status[cpu8ex_pkg::FLAG_U] = 1'b1;
            nxt.status[cpu8ex_pkg::FLAG_B] = 1'b0;
         end
         cpu8ex_pkg::KIND_STA: begin
            res_byte = a;
            wb       = 1'b1;
         end
         cpu8ex_pkg::KIND_STX: begin
            res_byte = regs_cur.x;
            wb       = 1'b1;
         end
         cpu8ex_pkg::KIND_STY: begin
            res_byte = regs_cur.y;
            wb       = 1'b1;
         end
         cpu8ex_pkg::KIND_BRANCH: begin
            taken = br_taken;
            if (br_taken) begin
               npc     = br_target;
               crossed = (br_target[15:8] != item.pc[15:8]);
            end
         end
         default: begin
            // read status and unused codes change nothing
         end
      endcase
   end

   // result assembly
   assign regs_next            = nxt;
   assign rsp_out.result_byte  = res_byte;
   assign rsp_out.write_back   = wb;
   assign rsp_out.status       = nxt.status;
   assign rsp_out.branch_taken = taken;
   assign rsp_out.next_pc      = npc;
   assign rsp_out.page_crossed = crossed;
   assign rsp_out.acc_out      = nxt.acc;
   assign rsp_out.x_out        = nxt.x;
   assign rsp_out.y_out        = nxt.y;
   assign rsp_out.sp_out       = nxt.sp;

endmodule
